[hw/rtl/ttcs_pkg.sv]
// ----------------------------------------------------------------------------
// ttcs_pkg
// Shared types and constants for the text terminal: item and result words,
// controller states, and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
package ttcs_pkg;

  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [7:0]  RESET_ATTR   = 8'h07;
  localparam logic [15:0] CLEAR_CELL   = {RESET_ATTR, SPACE_CODE};
  localparam logic [15:0] SCROLL_CELL  = {8'h00, SPACE_CODE};

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic        scrolled;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_PRIME,
    ST_COPY,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic latch_item;
    logic put;
    logic read_item;
    logic load_result;
    logic result_scrolled;
    logic prime;
    logic copy;
    logic fill;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic item_is_read;
    logic put_scrolls;
    logic ptr_last_copy;
    logic ptr_last_cell;
  } status_t;

endpackage

[hw/rtl/ttcs_ctrl.sv]
// ----------------------------------------------------------------------------
// ttcs_ctrl
// Sequencer: reset clear sweep, item execution, and the scroll copy/fill
// sweeps over the screen store.
// ----------------------------------------------------------------------------
module ttcs_ctrl import ttcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.ptr_last_cell) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.item_is_read) begin
          state_next = ST_READ;
        end else if (status.put_scrolls) begin
          state_next = ST_PRIME;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_READ:  state_next = ST_IDLE;
      ST_PRIME: state_next = ST_COPY;
      ST_COPY: begin
        if (status.ptr_last_copy) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (status.ptr_last_cell) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        busy           = 1'b0;
        cmd.latch_item = start;
      end
      ST_EXEC: begin
        if (status.item_is_read) begin
          cmd.read_item = 1'b1;
        end else begin
          cmd.put         = 1'b1;
          cmd.load_result = !status.put_scrolls;
        end
      end
      ST_READ:  cmd.load_result = 1'b1;
      ST_PRIME: cmd.prime = 1'b1;
      ST_COPY:  cmd.copy = 1'b1;
      ST_FILL: begin
        cmd.fill            = 1'b1;
        cmd.load_result     = status.ptr_last_cell;
        cmd.result_scrolled = 1'b1;
      end
      default:  busy = 1'b1;
    endcase
  end

endmodule

[hw/rtl/ttcs_datapath.sv]
// ----------------------------------------------------------------------------
// ttcs_datapath
// Screen store, cursor, attribute register, sweep pointer and result word.
// ----------------------------------------------------------------------------
module ttcs_datapath import ttcs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output status_t    status,
  input  item_t      item,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  output result_t    result,
  output logic       done
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [15:0]   screen [CELLS];
  logic [15:0]   rd_data;
  item_t         cur_item;
  logic [7:0]    text_color;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [AW-1:0] ptr;

  logic [RW-1:0] row_next;
  logic [CW-1:0] col_next;
  logic          is_newline;
  logic          wrap;
  logic          in_range;
  logic [AW-1:0] cursor_addr;
  logic [AW-1:0] item_addr;
  logic [AW:0]   copy_src;
  logic          we;
  logic [AW-1:0] wa;
  logic [15:0]   wd;
  logic          re;
  logic [AW-1:0] ra;

  assign is_newline  = (cur_item.char_code == NEWLINE_CODE);
  assign wrap        = is_newline || (col == CW'(COLUMNS - 1));
  assign in_range    = ({3'b000, cur_item.read_row} < 8'(ROWS)) &&
                       ({2'b00, cur_item.read_column} < 9'(COLUMNS));
  assign cursor_addr = AW'(row) * AW'(COLUMNS) + AW'(col);
  assign item_addr   = AW'(cur_item.read_row) * AW'(COLUMNS) + AW'(cur_item.read_column);
  // source cell for the read issued alongside the current copy write
  assign copy_src    = (AW + 1)'(ptr) + (AW + 1)'(COLUMNS + 1);

  assign status.item_is_read  = (cur_item.kind == KIND_READ);
  assign status.put_scrolls   = wrap && (row == RW'(ROWS - 1));
  assign status.ptr_last_copy = (ptr == AW'(CELLS - COLUMNS - 1));
  assign status.ptr_last_cell = (ptr == AW'(CELLS - 1));

  // cursor update for a put
  always_comb begin
    row_next = row;
    col_next = col;
    if (cmd.put) begin
      if (wrap) begin
        col_next = '0;
        if (row != RW'(ROWS - 1)) row_next = row + 1'b1;
      end else begin
        col_next = col + 1'b1;
      end
    end
  end

  // store port selection
  always_comb begin
    we = 1'b0;
    wa = ptr;
    wd = rd_data;
    re = 1'b0;
    ra = item_addr;
    if (cmd.clear) begin
      we = 1'b1;
      wd = CLEAR_CELL;
    end else if (cmd.put) begin
      we = !is_newline;
      wa = cursor_addr;
      wd = {text_color, cur_item.char_code};
    end else if (cmd.copy) begin
      we = 1'b1;
      re = (copy_src < (AW + 1)'(CELLS));
      ra = copy_src[AW-1:0];
    end else if (cmd.fill) begin
      we = 1'b1;
      wd = SCROLL_CELL;
    end else if (cmd.prime) begin
      re = 1'b1;
      ra = AW'(COLUMNS);
    end else if (cmd.read_item) begin
      re = in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (we) screen[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (re) rd_data <= screen[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) cur_item <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_ATTR;
      row        <= '0;
      col        <= '0;
      ptr        <= '0;
      done       <= 1'b0;
    end else begin
      if (cfg_write) text_color <= cfg_data;
      row  <= row_next;
      col  <= col_next;
      done <= cmd.load_result;
      if (cmd.prime) begin
        ptr <= '0;
      end else if (cmd.clear || cmd.copy || cmd.fill) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      result.cell_value    <= (status.item_is_read && in_range) ? rd_data : 16'h0000;
      result.cursor_row    <= 5'(row_next);
      result.cursor_column <= 7'(col_next);
      result.scrolled      <= cmd.result_scrolled;
    end
  end

endmodule

[hw/rtl/text_terminal_cursor_scroll.sv]
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll
// Character-cell terminal: puts characters at the cursor, wraps and scrolls
// the screen store, and reads back single cells.
//
//   channel   handshake            word
//   item      start / busy         item_t: kind, char_code, read_row, read_column
//   result    done (1-cycle)       result_t: cell_value, cursor, scrolled
//   config    cfg_valid/cfg_ready  cfg_data: attribute for new characters
//
// A put without scroll raises done from its EXEC state, a read from the READ
// state after EXEC (one more state for the registered store read). busy falls at
// the edge that raises done. A put that scrolls raises done at the end of
// its PRIME, COPY and FILL sweep: the store is walked one cell per cycle,
// set by its single write port. After reset the store is cleared one cell
// per cycle, busy high. The receiver cannot stall; done strobes for one cycle.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll import ttcs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  item_t      item,
  output logic       done,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  ttcs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ttcs_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item      (item),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .result    (result),
    .done      (done)
  );

endmodule
